/* sv/afp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afp_pkg
// Types, character codes and helpers shared by the frame parser modules.
// ----------------------------------------------------------------------------
package afp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] direction;
  } afp_in_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [6:0] value;
    logic [2:0] status;
    logic       crc_good;
    logic       more_blocks;
    logic       downlink;
    logic       last_result;
  } afp_out_t;

  // one entry of the front-to-back queue
  typedef struct packed {
    logic       has_byte;   // a frame byte has cleared the trailer lag
    logic [6:0] data;
    logic       first;      // first word of a frame, dir is valid
    logic [1:0] dir;
    logic       is_end;     // frame end, trailer checks below
    logic [2:0] fstat;
    logic       crc_good;
    logic       more;
    logic       len16;
    logic       len_short;
  } afp_evt_t;

  typedef enum logic [3:0] {
    PH_HDR, PH_STX, PH_MSGNO, PH_SUB, PH_MFI, PH_SUBE, PH_MFIE, PH_TEXT, PH_DROP
  } afp_phase_t;

  localparam logic [3:0] KIND_MODE     = 4'd0;
  localparam logic [3:0] KIND_REG      = 4'd1;
  localparam logic [3:0] KIND_ACK      = 4'd2;
  localparam logic [3:0] KIND_LABEL    = 4'd3;
  localparam logic [3:0] KIND_BLOCK    = 4'd4;
  localparam logic [3:0] KIND_MSGNO    = 4'd5;
  localparam logic [3:0] KIND_FLIGHT   = 4'd6;
  localparam logic [3:0] KIND_SUBLABEL = 4'd7;
  localparam logic [3:0] KIND_MFI      = 4'd8;
  localparam logic [3:0] KIND_TEXT     = 4'd9;
  localparam logic [3:0] KIND_SUMMARY  = 4'd10;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_NO_DEL     = 3'd2;
  localparam logic [2:0] ST_NO_ETX     = 3'd3;
  localparam logic [2:0] ST_NO_DL_TEXT = 3'd4;
  localparam logic [2:0] ST_NO_STX     = 3'd5;
  localparam logic [2:0] ST_SHORT_DL   = 3'd6;
  localparam logic [2:0] ST_OVERLONG   = 3'd7;

  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_A2G     = 2'd1;
  localparam logic [1:0] DIR_G2A     = 2'd2;

  localparam logic [7:0] RAW_DEL  = 8'h7f;
  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_STX   = 7'h02;
  localparam logic [6:0] CH_ETX   = 7'h03;
  localparam logic [6:0] CH_ACK   = 7'h06;
  localparam logic [6:0] CH_NAK   = 7'h15;
  localparam logic [6:0] CH_ETB   = 7'h17;
  localparam logic [6:0] CH_DEL   = 7'h7f;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_BANG  = 7'h21;
  localparam logic [6:0] CH_HASH  = 7'h23;
  localparam logic [6:0] CH_DASH  = 7'h2d;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_SLASH = 7'h2f;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_ONE   = 7'h31;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_B     = 7'h42;
  localparam logic [6:0] CH_H     = 7'h48;
  localparam logic [6:0] CH_CARET = 7'h5e;
  localparam logic [6:0] CH_D     = 7'h64;

  localparam int MIN_FRAME  = 16;
  localparam int HOLD_LAG   = 3;
  localparam int SHORT_DL   = 26;
  localparam int QDEPTH     = 4;
  localparam int LOOK_DEPTH = 5;

  localparam logic [3:0] HDR_LAST    = 4'd11;
  localparam logic [3:0] HDR_REG_END = 4'd7;
  localparam logic [3:0] HDR_ACK     = 4'd8;
  localparam logic [3:0] HDR_LBL1    = 4'd9;
  localparam logic [3:0] HDR_LBL2    = 4'd10;
  localparam logic [3:0] MSGNO_SPLIT = 4'd4;
  localparam logic [3:0] MSGNO_LAST  = 4'd9;

  // reflected CCITT, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [6:0] text_char(input logic [6:0] v);
    return (v == CH_NUL) ? CH_DOT : v;
  endfunction

endpackage
`default_nettype wire

/* sv/acars_frame_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acars_frame_parser_top
// Streaming parser for one ACARS frame at a time, tagged field output.
// ----------------------------------------------------------------------------
// in channel: one raw frame byte per word (SOH excluded), last_byte on the DEL,
//   direction sampled on the first word of each frame.
// out channel: tagged characters in frame order, then one summary word
//   (last_result set) per frame. Words before a summary with nonzero status
//   are provisional and should be discarded by the consumer.
// Throughput: one input word per cycle while in_stall is low. A byte is released
//   three words after it arrives (trailer lag), then passes the queue and the
//   output register. A sublabel or MFI match holds the back parser while the
//   pair goes out after its bytes are taken; a lookahead miss replays its four
//   or five held bytes as text, and at the end of a frame with OK status up to
//   four held bytes are flushed as text before the summary. The four-word queue
//   between front and back takes up these bursts; in_stall rises only when it is
//   full.
// Reset (rst, synchronous) returns to the start of a frame with empty queue.
// When out_stall is high the result word holds; the back parser waits while
//   the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module acars_frame_parser_top #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire afp_pkg::afp_in_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output afp_pkg::afp_out_t      out_word
);

  afp_pkg::afp_evt_t evt_in, evt_out;
  logic take, evt_push, q_full, q_pop, q_valid;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  afp_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .take     (take),
    .evt      (evt_in),
    .evt_push (evt_push)
  );

  afp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (evt_push),
    .din       (evt_in),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (evt_out),
    .not_empty (q_valid)
  );

  afp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev        (evt_out),
    .ev_valid  (q_valid),
    .ev_pop    (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

/* sv/afp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afp_front
// Takes raw bytes: CRC, length count, trailer lag and frame-end checks.
// ----------------------------------------------------------------------------
module afp_front #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire afp_pkg::afp_in_t  in_word,
  input  wire logic              take,
  output afp_pkg::afp_evt_t      evt,
  output logic                   evt_push
);

  localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);

  logic [15:0]     crc;
  logic [PosW-1:0] pos;
  logic            ovl;
  logic [6:0]      d0, d1, d2;

  logic ovl_now;
  logic tail_ok;

  always_comb begin
    ovl_now = ovl || (pos >= PosW'(MAX_FRAME_BYTES));
    tail_ok = (d2 == afp_pkg::CH_ETX) || (d2 == afp_pkg::CH_ETB);

    evt.has_byte = !ovl_now && !in_word.last_byte && (pos >= PosW'(afp_pkg::HOLD_LAG));
    evt.data     = d2;
    evt.first    = (pos == '0) && !ovl;
    evt.dir      = in_word.direction;
    evt.is_end   = in_word.last_byte;
    priority if (ovl_now)                               evt.fstat = afp_pkg::ST_OVERLONG;
    else if (pos < PosW'(afp_pkg::MIN_FRAME - 1))       evt.fstat = afp_pkg::ST_SHORT;
    else if (in_word.data_byte != afp_pkg::RAW_DEL)     evt.fstat = afp_pkg::ST_NO_DEL;
    else if (!tail_ok)                                  evt.fstat = afp_pkg::ST_NO_ETX;
    else                                                evt.fstat = afp_pkg::ST_OK;
    evt.crc_good  = !ovl_now && (crc == 16'h0000);
    evt.more      = (evt.fstat == afp_pkg::ST_OK) && (d2 == afp_pkg::CH_ETB);
    evt.len16     = (pos == PosW'(afp_pkg::MIN_FRAME - 1));
    evt.len_short = (pos <= PosW'(afp_pkg::SHORT_DL - 1));

    evt_push = take && (evt.has_byte || evt.first || evt.is_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
      pos <= '0;
      ovl <= 1'b0;
    end else if (take) begin
      if (in_word.last_byte) begin
        crc <= '0;
        pos <= '0;
        ovl <= 1'b0;
      end else if (ovl_now) begin
        ovl <= 1'b1;
      end else begin
        crc <= afp_pkg::crc_byte(crc, in_word.data_byte);
        pos <= pos + PosW'(1);
      end
    end
  end

  // trailer lag: a byte is released three words later
  always_ff @(posedge clk) begin
    if (take && !ovl_now) begin
      d0 <= in_word.data_byte[6:0];
      d1 <= d0;
      d2 <= d1;
    end
  end

endmodule
`default_nettype wire

/* sv/afp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afp_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module afp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire afp_pkg::afp_evt_t  din,
  output logic                    full,
  input  wire logic               pop,
  output afp_pkg::afp_evt_t       dout,
  output logic                    not_empty
);

  localparam int Depth = afp_pkg::QDEPTH;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  afp_pkg::afp_evt_t entry [Depth];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  always_comb begin
    full      = (count == CW'(Depth));
    not_empty = (count != '0);
    dout      = entry[rptr];
    do_push   = push && !full;
    do_pop    = pop && not_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + AW'(1);
      if (do_pop)  rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wptr] <= din;
  end

endmodule
`default_nettype wire

/* sv/afp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afp_back
// Field parser: tags released bytes, sublabel/MFI lookahead, frame summary.
// ----------------------------------------------------------------------------
module afp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire afp_pkg::afp_evt_t  ev,
  input  wire logic               ev_valid,
  output logic                    ev_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output afp_pkg::afp_out_t       out_word
);

  localparam int LD = afp_pkg::LOOK_DEPTH;
  localparam int LW = $clog2(LD + 1);

  afp_pkg::afp_phase_t phase, phase_next;
  logic [3:0]    cnt, cnt_next;
  logic [LW-1:0] lc, lc_next;
  logic [6:0]    lb [LD];
  logic [6:0]    lb_next [LD];
  logic [6:0]    lb_new [LD];
  logic [1:0]    frame_dir, frame_dir_next;
  logic          blk, blk_next;
  logic [6:0]    lbl1, lbl1_next, lbl2, lbl2_next;
  logic          pair_hi, pair_hi_next;

  logic o_free, in_pair, act_pair, act_flush, act_ev, end_hold;
  logic act_sum, act_byte, emit;
  logic [1:0] dir_eff, guess_dir;
  logic h1_ok, blk_dig, buf_full, sub_hit, mfi_hit, g2a;
  logic [6:0] v, tv, blk_v;
  logic [LW-1:0] need;
  logic [2:0] sum_status;
  afp_pkg::afp_phase_t after_text;
  afp_pkg::afp_out_t ow;

  // shared decode
  always_comb begin
    o_free    = !out_valid || !out_stall;
    in_pair   = (phase == afp_pkg::PH_SUBE) || (phase == afp_pkg::PH_MFIE);
    act_pair  = o_free && in_pair;
    act_flush = o_free && !in_pair && (phase == afp_pkg::PH_TEXT) && (lc != '0);
    act_ev    = o_free && !in_pair && !((phase == afp_pkg::PH_TEXT) && (lc != '0)) && ev_valid;
    // with an OK frame status, pending lookahead is flushed as text before the summary
    end_hold  = ev.is_end && (ev.fstat == afp_pkg::ST_OK) && (lc != '0);
    ev_pop    = act_ev && !end_hold;
    act_sum   = act_ev && ev.is_end && !end_hold;
    act_byte  = act_ev && !ev.is_end && ev.has_byte;
    dir_eff   = ev.first ? ev.dir : frame_dir;
    g2a       = (frame_dir == afp_pkg::DIR_G2A);

    h1_ok = (lbl1 == afp_pkg::CH_H) && (lbl2 == afp_pkg::CH_ONE) &&
            ((frame_dir == afp_pkg::DIR_A2G) || g2a);
    after_text = h1_ok ? afp_pkg::PH_SUB : afp_pkg::PH_TEXT;

    v       = ev.data;
    tv      = afp_pkg::text_char(v);
    blk_v   = (v == afp_pkg::CH_NUL) ? afp_pkg::CH_SPACE : v;
    blk_dig = (blk_v >= afp_pkg::CH_ZERO) && (blk_v <= afp_pkg::CH_NINE);
    guess_dir = (frame_dir == afp_pkg::DIR_UNKNOWN) ?
                (blk_dig ? afp_pkg::DIR_A2G : afp_pkg::DIR_G2A) : frame_dir;

    for (int i = 0; i < LD; i++) begin
      lb_new[i] = (lc == LW'(i)) ? tv : lb[i];
    end
    need     = ((phase == afp_pkg::PH_SUB) && g2a) ? LW'(5) : LW'(4);
    buf_full = ((lc + LW'(1)) == need);
    sub_hit  = g2a ? ((lb_new[0] == afp_pkg::CH_DASH) && (lb_new[1] == afp_pkg::CH_SPACE) &&
                      (lb_new[2] == afp_pkg::CH_HASH))
                   : ((lb_new[0] == afp_pkg::CH_HASH) && (lb_new[3] == afp_pkg::CH_B));
    mfi_hit  = (lb_new[0] == afp_pkg::CH_SLASH) && (lb_new[3] == afp_pkg::CH_SPACE);

    priority if (ev.fstat != afp_pkg::ST_OK)
      sum_status = ev.fstat;
    else if (ev.len16)
      sum_status = blk ? afp_pkg::ST_NO_DL_TEXT : afp_pkg::ST_OK;
    else if (phase == afp_pkg::PH_DROP)
      sum_status = afp_pkg::ST_NO_STX;
    else if (blk && ev.len_short)
      sum_status = afp_pkg::ST_SHORT_DL;
    else
      sum_status = afp_pkg::ST_OK;
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (act_pair && pair_hi) begin
      phase_next = (phase == afp_pkg::PH_SUBE) ? afp_pkg::PH_MFI : afp_pkg::PH_TEXT;
    end else if (act_ev && ev.is_end) begin
      phase_next = end_hold ? afp_pkg::PH_TEXT : afp_pkg::PH_HDR;
    end else if (act_byte) begin
      unique case (phase)
        afp_pkg::PH_HDR: begin
          if (cnt == afp_pkg::HDR_LAST) phase_next = afp_pkg::PH_STX;
        end
        afp_pkg::PH_STX: begin
          if (v != afp_pkg::CH_STX) phase_next = afp_pkg::PH_DROP;
          else                      phase_next = blk ? afp_pkg::PH_MSGNO : after_text;
        end
        afp_pkg::PH_MSGNO: begin
          if (cnt == afp_pkg::MSGNO_LAST) phase_next = after_text;
        end
        afp_pkg::PH_SUB: begin
          if (buf_full) phase_next = sub_hit ? afp_pkg::PH_SUBE : afp_pkg::PH_TEXT;
        end
        afp_pkg::PH_MFI: begin
          if (buf_full) phase_next = mfi_hit ? afp_pkg::PH_MFIE : afp_pkg::PH_TEXT;
        end
        default: ;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    emit           = 1'b0;
    ow             = '0;
    ow.downlink    = (frame_dir == afp_pkg::DIR_A2G);
    cnt_next       = cnt;
    lc_next        = lc;
    lb_next        = lb;
    frame_dir_next = frame_dir;
    blk_next       = blk;
    lbl1_next      = lbl1;
    lbl2_next      = lbl2;
    pair_hi_next   = pair_hi;

    if (act_pair) begin
      emit    = 1'b1;
      ow.kind = (phase == afp_pkg::PH_SUBE) ? afp_pkg::KIND_SUBLABEL : afp_pkg::KIND_MFI;
      if (pair_hi) begin
        ow.value     = ((phase == afp_pkg::PH_SUBE) && g2a) ? lb[4] : lb[2];
        lc_next      = '0;
        pair_hi_next = 1'b0;
      end else begin
        ow.value     = ((phase == afp_pkg::PH_SUBE) && g2a) ? lb[3] : lb[1];
        pair_hi_next = 1'b1;
      end
    end else if (act_flush) begin
      emit     = 1'b1;
      ow.kind  = afp_pkg::KIND_TEXT;
      ow.value = lb[0];
      for (int i = 0; i < LD - 1; i++) lb_next[i] = lb[i+1];
      lc_next  = lc - LW'(1);
    end else if (act_ev) begin
      if (ev.first) frame_dir_next = ev.dir;
      if (act_sum) begin
        emit           = 1'b1;
        ow.kind        = afp_pkg::KIND_SUMMARY;
        ow.status      = sum_status;
        ow.crc_good    = ev.crc_good;
        ow.more_blocks = ev.more;
        ow.downlink    = (dir_eff == afp_pkg::DIR_A2G);
        ow.last_result = 1'b1;
        cnt_next       = '0;
        lc_next        = '0;
        frame_dir_next = afp_pkg::DIR_UNKNOWN;
        blk_next       = 1'b0;
        lbl1_next      = afp_pkg::CH_NUL;
        lbl2_next      = afp_pkg::CH_NUL;
        pair_hi_next   = 1'b0;
      end else if (act_byte) begin
        unique case (phase)
          afp_pkg::PH_HDR: begin
            emit     = 1'b1;
            ow.value = v;
            cnt_next = (cnt == afp_pkg::HDR_LAST) ? 4'd0 : cnt + 4'd1;
            priority if (cnt == 4'd0) begin
              ow.kind = afp_pkg::KIND_MODE;
            end else if (cnt <= afp_pkg::HDR_REG_END) begin
              ow.kind = afp_pkg::KIND_REG;
            end else if (cnt == afp_pkg::HDR_ACK) begin
              ow.kind = afp_pkg::KIND_ACK;
              if (v == afp_pkg::CH_NAK)      ow.value = afp_pkg::CH_BANG;
              else if (v == afp_pkg::CH_ACK) ow.value = afp_pkg::CH_CARET;
            end else if (cnt == afp_pkg::HDR_LBL1) begin
              ow.kind   = afp_pkg::KIND_LABEL;
              lbl1_next = v;
            end else if (cnt == afp_pkg::HDR_LBL2) begin
              ow.kind   = afp_pkg::KIND_LABEL;
              ow.value  = (v == afp_pkg::CH_DEL) ? afp_pkg::CH_D : v;
              lbl2_next = ow.value;
            end else begin
              ow.kind        = afp_pkg::KIND_BLOCK;
              ow.value       = blk_v;
              blk_next       = blk_dig;
              frame_dir_next = guess_dir;
              ow.downlink    = (guess_dir == afp_pkg::DIR_A2G);
            end
          end
          afp_pkg::PH_STX: cnt_next = '0;
          afp_pkg::PH_MSGNO: begin
            emit     = 1'b1;
            ow.kind  = (cnt < afp_pkg::MSGNO_SPLIT) ? afp_pkg::KIND_MSGNO
                                                    : afp_pkg::KIND_FLIGHT;
            ow.value = tv;
            cnt_next = cnt + 4'd1;
          end
          afp_pkg::PH_SUB, afp_pkg::PH_MFI: begin
            lb_next = lb_new;
            lc_next = lc + LW'(1);
          end
          afp_pkg::PH_TEXT: begin
            emit     = 1'b1;
            ow.kind  = afp_pkg::KIND_TEXT;
            ow.value = tv;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= afp_pkg::PH_HDR;
      cnt       <= '0;
      lc        <= '0;
      frame_dir <= afp_pkg::DIR_UNKNOWN;
      blk       <= 1'b0;
      lbl1      <= afp_pkg::CH_NUL;
      lbl2      <= afp_pkg::CH_NUL;
      pair_hi   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      lc        <= lc_next;
      frame_dir <= frame_dir_next;
      blk       <= blk_next;
      lbl1      <= lbl1_next;
      lbl2      <= lbl2_next;
      pair_hi   <= pair_hi_next;
      if (emit)        out_valid <= 1'b1;
      else if (o_free) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    lb <= lb_next;
    if (emit) out_word <= ow;
  end

endmodule
`default_nettype wire

/* sv/afp_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afp_check
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module afp_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire afp_pkg::afp_in_t  in_word,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire afp_pkg::afp_out_t out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.kind != afp_pkg::KIND_SUMMARY) |->
      (out_word.status == afp_pkg::ST_OK) && !out_word.crc_good &&
      !out_word.more_blocks && !out_word.last_result)
    else $error("summary flags on a character word");

  a_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.kind == afp_pkg::KIND_SUMMARY) |->
      out_word.last_result && (out_word.value == 7'd0) &&
      !(out_word.more_blocks && (out_word.status == afp_pkg::ST_OVERLONG)))
    else $error("malformed summary word");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind acars_frame_parser_top afp_check u_check (.*);
`default_nettype wire
